// ===== hw/rtl/lpwq_pkg.sv =====
// ============================================================================
// lpwq_pkg - shared definitions for the lock pool with wait queue
// Field widths, command and status codes, controller states and the
// command/status bundles between controller and datapath.
// ============================================================================
package lpwq_pkg;

    // default sizes
    localparam int LOCKS_DEF       = 8;
    localparam int QUEUE_DEPTH_DEF = 16;

    // item field widths
    localparam int CMD_W    = 2;
    localparam int NUM_W    = 6;
    localparam int TAG_W    = 8;
    localparam int STATUS_W = 3;
    localparam int GRANT_W  = 6;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ACQUIRE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_GRANTED  = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_QUEUED   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_RELEASED = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_INVALID  = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_QUERY    = 3'd5;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic capture;  // load the incoming item
        logic commit;   // apply the item and load the result register
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_busy; // result register holds an item not taken this cycle
    } t_dp_status;

endpackage

// ===== hw/rtl/lpwq_ctrl.sv =====
// ============================================================================
// lpwq_ctrl - sequencing controller
// Takes one item, holds it in the execute state and commits it once the
// result register can take the answer.
// ============================================================================
module lpwq_ctrl
    import lpwq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (!i_status.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready    = 1'b1;
                o_cmd.capture = i_s_tvalid;
            end
            S_EXEC: begin
                o_cmd.commit = !i_status.out_busy;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/lpwq_dp.sv =====
// ============================================================================
// lpwq_dp - lock bitmap, wait queue and result register
// Lowest-free-lock search, queue memory with head/tail/count, and the
// output register that feeds the result stream.
// ============================================================================
module lpwq_dp
    import lpwq_pkg::*;
#(
    parameter int LOCKS       = LOCKS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ctrl_cmd           i_cmd,
    output t_dp_status          o_status,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [NUM_W-1:0]    i_lock_number,
    input  logic [TAG_W-1:0]    i_requester_tag,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_res_status,
    output logic [GRANT_W-1:0]  o_granted_lock,
    output logic                o_held,
    output logic                o_wake_valid,
    output logic [TAG_W-1:0]    o_wake_tag
);

    localparam int LOCK_W = (LOCKS > 1) ? $clog2(LOCKS) : 1;
    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    // captured item
    logic [CMD_W-1:0] r_command;
    logic [NUM_W-1:0] r_num;
    logic [TAG_W-1:0] r_tag;

    // pool and queue state
    logic [LOCKS-1:0] r_held_bits, n_held_bits;
    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic [TAG_W-1:0] r_queue_mem [QUEUE_DEPTH];
    logic [TAG_W-1:0] r_head_tag;

    // result register
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic [GRANT_W-1:0]  r_granted, n_granted;
    logic                r_held, n_held;
    logic                r_wake_valid, n_wake_valid;
    logic [TAG_W-1:0]    r_wake_tag, n_wake_tag;

    logic              num_ok;
    logic [LOCK_W-1:0] num_idx;
    logic              any_free;
    logic [LOCK_W-1:0] free_idx;
    logic              q_full;
    logic              q_empty;
    logic              do_push;
    logic              do_pop;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_command <= i_command;
            r_num     <= i_lock_number;
            r_tag     <= i_requester_tag;
        end
    end

    assign num_ok  = {1'b0, r_num} < (NUM_W+1)'(LOCKS);
    assign num_idx = LOCK_W'(r_num);
    assign q_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign q_empty = (r_count == '0);

    // lowest-numbered free lock
    always_comb begin
        any_free = 1'b0;
        free_idx = '0;
        for (int i = LOCKS - 1; i >= 0; i--) begin
            if (!r_held_bits[i]) begin
                any_free = 1'b1;
                free_idx = LOCK_W'(i);
            end
        end
    end

    always_comb begin
        n_held_bits  = r_held_bits;
        n_res_status = STAT_INVALID;
        n_granted    = '0;
        n_held       = 1'b0;
        n_wake_valid = 1'b0;
        n_wake_tag   = '0;
        do_push      = 1'b0;
        do_pop       = 1'b0;
        unique case (r_command)
            CMD_ACQUIRE: begin
                if (any_free) begin
                    n_held_bits[free_idx] = 1'b1;
                    n_granted             = GRANT_W'(free_idx);
                    n_res_status          = STAT_GRANTED;
                end else if (q_full) begin
                    n_res_status = STAT_FULL;
                end else begin
                    do_push      = 1'b1;
                    n_res_status = STAT_QUEUED;
                end
            end
            CMD_RELEASE: begin
                if (num_ok) begin
                    n_held_bits[num_idx] = 1'b0;
                    n_res_status         = STAT_RELEASED;
                    if (!q_empty) begin
                        do_pop       = 1'b1;
                        n_wake_valid = 1'b1;
                        n_wake_tag   = r_head_tag;
                    end
                end
            end
            CMD_QUERY: begin
                if (num_ok) begin
                    n_held       = r_held_bits[num_idx];
                    n_res_status = STAT_QUERY;
                end
            end
            default: begin
                n_res_status = STAT_INVALID;
            end
        endcase
    end

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (do_push) begin
            n_tail  = (r_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
            n_count = r_count + 1'b1;
        end
        if (do_pop) begin
            n_head  = (r_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_bits <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
        end else if (i_cmd.commit) begin
            r_held_bits <= n_held_bits;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
        end
    end

    // queue memory; head entry read every cycle, settled before the next commit
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && do_push) begin
            r_queue_mem[r_tail] <= r_tag;
        end
        r_head_tag <= r_queue_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_res_status <= n_res_status;
            r_granted    <= n_granted;
            r_held       <= n_held;
            r_wake_valid <= n_wake_valid;
            r_wake_tag   <= n_wake_tag;
        end
    end

    assign o_status.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_res_status      = r_res_status;
    assign o_granted_lock    = r_granted;
    assign o_held            = r_held;
    assign o_wake_valid      = r_wake_valid;
    assign o_wake_tag        = r_wake_tag;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("wait queue count above depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == r_tail))
        else $error("empty queue with head and tail apart");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && do_pop) |=> (r_count == $past(r_count) - 1'b1))
        else $error("wake-up without queue count decrement");

    a_grant_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && (n_res_status == STAT_GRANTED))
            |=> r_held_bits[$past(free_idx)])
        else $error("granted lock not marked held");
`endif

endmodule

// ===== hw/rtl/lock_pool_with_wait_queue_unit.sv =====
// ============================================================================
// lock_pool_with_wait_queue_unit - lock pool with FIFO of waiting requesters
// Top level: stream ports, controller and datapath.
// ============================================================================
// A pool of LOCKS binary locks with a wait queue of QUEUE_DEPTH requester
// tags. Every input item gives exactly one result item. An acquire takes
// the lowest-numbered free lock (status granted); with none free the tag
// is queued (status queued) or, with the queue full, refused (status
// queue full). A valid release frees the lock and, if anyone waits, pops
// the oldest tag as a wake-up; the freed lock stays free and is not handed
// over. A query reports the held bit. Lock numbers at or above LOCKS on a
// release or query, and the unused command code, give status invalid and
// change nothing. Items are handled one at a time: an item is taken in the
// idle state and executed in the execute state, so the block takes no new
// item before the last one is committed. The result sits in an output
// register, so the next item is taken while the previous result waits; a
// stalled result holds the execute step of the following item. After
// reset all locks are free and the queue is empty; queue memory contents
// need no clearing.
module lock_pool_with_wait_queue_unit
    import lpwq_pkg::*;
#(
    parameter int LOCKS       = LOCKS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input items
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,  // [5:0] lock_number, [13:6] requester_tag, [15:14] 0
    input  logic [CMD_W-1:0]    s_tuser,  // [1:0] command
    // result items
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,  // [5:0] granted_lock, [6] held, [7] wake_valid,
                                          // [15:8] wake_tag
    output logic [STATUS_W-1:0] m_tuser   // [2:0] status
);

    t_ctrl_cmd  ctrl_cmd;
    t_dp_status dp_status;

    logic [GRANT_W-1:0] granted_lock;
    logic               held;
    logic               wake_valid;
    logic [TAG_W-1:0]   wake_tag;

    lpwq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_status   (dp_status),
        .o_cmd      (ctrl_cmd)
    );

    lpwq_dp #(
        .LOCKS       (LOCKS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (ctrl_cmd),
        .o_status        (dp_status),
        .i_command       (s_tuser),
        .i_lock_number   (s_tdata[NUM_W-1:0]),
        .i_requester_tag (s_tdata[NUM_W+TAG_W-1:NUM_W]),
        .o_out_valid     (m_tvalid),
        .i_out_ready     (m_tready),
        .o_res_status    (m_tuser),
        .o_granted_lock  (granted_lock),
        .o_held          (held),
        .o_wake_valid    (wake_valid),
        .o_wake_tag      (wake_tag)
    );

    assign m_tdata = {wake_tag, wake_valid, held, granted_lock};

endmodule
